[rtl/core/tilt_complementary_filter_defines.svh]
// assertion macros for the tilt filter core
`ifndef TILT_COMPLEMENTARY_FILTER_DEFINES_SVH
`define TILT_COMPLEMENTARY_FILTER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define TCF_ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tilt filter assertion failed");
`define TCF_ASSERT(label, prop) \
    `TCF_ASSERT_CLK(label, i_clk, i_rst_n, prop)
`else
`define TCF_ASSERT_CLK(label, clk, rst_n, prop)
`define TCF_ASSERT(label, prop)
`endif

`endif

[rtl/core/tcf_pkg.sv]
`timescale 1ns / 1ps

package tcf_pkg;

    localparam int CORDIC_ITERATIONS_DEF = 16;
    localparam int FRACTION_BITS_DEF     = 16;

    // field and port widths
    localparam int IN_W        = 16;
    localparam int ANGLE_W     = 28;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int IN_TDATA_W  = 3 * IN_W;
    localparam int OUT_TDATA_W = ((ANGLE_W + 7) / 8) * 8;

    // cordic table: atan(2^-i) in degrees, 24 fraction bits
    localparam int TABLE_BITS = 24;
    localparam int TABLE_LEN  = 24;
    localparam int TAB_IDX_W  = 5;
    localparam int ATAN_W     = 30;

    // blend weight and time step carry 16 fraction bits
    localparam int W_FRAC = 16;

    // gyro scale: 131 counts per degree per second
    localparam int GYRO_DIVISOR = 131;
    localparam int REM_W        = 8;

    // divide by 131 one byte at a time: floor(t / 131) = (t * GYRO_RECIP) >> GYRO_RECIP_SH
    // for every t below 2^16
    localparam int DIG_W         = 8;
    localparam int RECIP_W       = 17;
    localparam int GYRO_RECIP_SH = 24;
    localparam logic [RECIP_W-1:0] GYRO_RECIP = 17'd128071;

    localparam int MUL_A_W = IN_W + 2;

    localparam logic [CFG_W-1:0] TIME_STEP_RST   = 16'd4588;
    localparam logic [CFG_W-1:0] GYRO_WEIGHT_RST = 16'd64225;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACCEL_X_OFS = 3'd0,
        CFG_ACCEL_Y_OFS = 3'd1,
        CFG_GYRO_Z_OFS  = 3'd2,
        CFG_TIME_STEP   = 3'd3,
        CFG_GYRO_WEIGHT = 3'd4
    } t_cfg_idx;

    function automatic logic [ATAN_W-1:0] atan_deg(input logic [TAB_IDX_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = 30'd754974720;
            5'd1:    v = 30'd445687602;
            5'd2:    v = 30'd235489088;
            5'd3:    v = 30'd119537938;
            5'd4:    v = 30'd60000934;
            5'd5:    v = 30'd30029717;
            5'd6:    v = 30'd15018523;
            5'd7:    v = 30'd7509720;
            5'd8:    v = 30'd3754917;
            5'd9:    v = 30'd1877466;
            5'd10:   v = 30'd938734;
            5'd11:   v = 30'd469367;
            5'd12:   v = 30'd234684;
            5'd13:   v = 30'd117342;
            5'd14:   v = 30'd58671;
            5'd15:   v = 30'd29335;
            5'd16:   v = 30'd14668;
            5'd17:   v = 30'd7334;
            5'd18:   v = 30'd3667;
            5'd19:   v = 30'd1833;
            5'd20:   v = 30'd917;
            5'd21:   v = 30'd458;
            5'd22:   v = 30'd229;
            5'd23:   v = 30'd115;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[rtl/core/tilt_complementary_filter.sv]
`timescale 1ns / 1ps
// Tilt complementary filter. One beat on the input stream carries a raw IMU sample
// (accelerometer X and Y, gyro Z). The core adds the configured offsets, finds the
// accelerometer tilt atan2(ay, ax) in degrees with a vectoring CORDIC, integrates
// -gz/131 * time_step onto the stored angle, blends the two with gyro_weight and
// returns the saturated new angle (signed, FRACTION_BITS fraction bits) as one
// output beat. The core takes one sample at a time: it does not take a new sample
// until the result of the last one is loaded into the output register, and a
// stalled output beat holds the core for as long as it waits. Ready returns the
// cycle after the result is loaded into the output register. The iteration state
// ends when both the CORDIC iterations and the divide by 131 of the gyro step are
// done; the divide runs alongside them on the shared step counter, one byte per
// cycle by reciprocal multiplication. A single multiplier is reused for the gyro
// product and the two blend products.
// Configuration writes are taken at any time but must only be issued while idle.

`include "tilt_complementary_filter_defines.svh"

module tilt_complementary_filter #(
    parameter int CORDIC_ITERATIONS = tcf_pkg::CORDIC_ITERATIONS_DEF,
    parameter int FRACTION_BITS     = tcf_pkg::FRACTION_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // accel_x_raw [15:0], accel_y_raw [31:16], gyro_z_raw [47:32]
    input  logic [tcf_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // tilt_angle [27:0], zero fill [31:28]
    output logic [tcf_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,
    input  logic                                i_cfg_we,
    input  logic [tcf_pkg::CFG_IDX_W-1:0]       i_cfg_addr,
    input  logic [tcf_pkg::CFG_W-1:0]           i_cfg_wdata
);

    import tcf_pkg::*;

    localparam int NITER    = (CORDIC_ITERATIONS > TABLE_LEN) ? TABLE_LEN : CORDIC_ITERATIONS;
    localparam int RND_SH   = TABLE_BITS - FRACTION_BITS;
    localparam int DIV_W    = FRACTION_BITS + 17;
    localparam int NDIG     = (DIV_W + DIG_W - 1) / DIG_W;
    localparam int DVD_W    = NDIG * DIG_W;
    localparam int T_W      = REM_W + DIG_W;
    localparam int P_W      = T_W + RECIP_W;
    localparam int Q_W      = FRACTION_BITS + 10;
    localparam int M_W      = FRACTION_BITS + 17;
    localparam int ITER_CYC = (NITER > NDIG) ? NITER : NDIG;
    localparam int CNT_W    = $clog2(ITER_CYC + 1);
    localparam int TG_W     = (FRACTION_BITS + 12 > ANGLE_W + 1) ? FRACTION_BITS + 12
                                                                  : ANGLE_W + 1;
    localparam int PROD_W   = MUL_A_W + TG_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int N_W      = PROD_W + FRACTION_BITS + 1;
    localparam int XW       = IN_W + TABLE_BITS + 3;
    localparam int ZW       = TABLE_BITS + 10;
    localparam int TA_W     = ZW - RND_SH;

    localparam logic signed [ZW-1:0]    BASE_180  = ZW'(180) << TABLE_BITS;
    localparam logic signed [ZW-1:0]    Z_HALF    = ZW'(1) << (RND_SH - 1);
    localparam logic signed [N_W-1:0]   GYRO_RND  = N_W'(GYRO_DIVISOR) << (W_FRAC - 1);
    localparam logic [DIV_W-1:0]        NEG_BIAS  = DIV_W'(GYRO_DIVISOR);
    localparam logic signed [SUM_W-1:0] BLEND_RND = SUM_W'(1) << (W_FRAC - 1);
    localparam logic signed [SUM_W-1:0] SAT_MAX   = (SUM_W'(1) << (ANGLE_W - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] SAT_MIN   = -(SUM_W'(1) << (ANGLE_W - 1));

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_PREP  = 10'b0000000010,
        S_SCALE = 10'b0000000100,
        S_ABS   = 10'b0000001000,
        S_ITER  = 10'b0000010000,
        S_ROUND = 10'b0000100000,
        S_MUL1  = 10'b0001000000,
        S_MUL2  = 10'b0010000000,
        S_SUM   = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    // configuration
    logic signed [IN_W-1:0]  r_ax_ofs, r_ay_ofs, r_gz_ofs;
    logic [CFG_W-1:0]        r_time_step, r_weight;

    // control
    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_out_valid;
    logic signed [ANGLE_W-1:0] r_angle;

    // datapath
    logic signed [IN_W-1:0]  r_ax, r_ay, r_gz;
    logic signed [PROD_W-1:0] r_prod, r_prod_a;
    logic signed [M_W-1:0]   r_m;
    logic [DVD_W-1:0]        r_dvd, r_quo;
    logic [REM_W-1:0]        r_rem;
    logic                    r_neg;
    logic signed [XW-1:0]    r_x, r_y;
    logic signed [ZW-1:0]    r_z;
    logic                    r_zero;
    logic signed [TA_W-1:0]  r_ta;
    logic signed [TG_W-1:0]  r_tg;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [ANGLE_W-1:0] r_out_data;

    logic                    in_beat, out_load;
    logic signed [IN_W-1:0]  in_ax, in_ay, in_gz;

    // shared multiplier
    logic signed [MUL_A_W-1:0] mul_a, gz_ext;
    logic signed [TG_W-1:0]    mul_b, ta_ext;
    logic signed [PROD_W-1:0]  mul_p;
    logic [CFG_W:0]            w_comp;

    // gyro scaling
    logic signed [N_W-1:0]   prod_ext, n_wide, n_shift;
    logic [DIV_W-1:0]        m_bits, n_dvd;

    // cordic step
    logic [TAB_IDX_W-1:0]    sh;
    logic signed [XW-1:0]    xs, ys, ax_ext, ay_ext, x0, y0;
    logic signed [ZW-1:0]    atan_z, base, z_fin, z_sh;

    // divider step, one byte of the dividend per cycle
    logic [T_W-1:0]          dig_t, dig_r;
    logic [P_W-1:0]          dig_p;
    logic [DIG_W-1:0]        dig_q;

    // round and blend
    logic signed [TG_W-1:0]  angle_ext, q_ext, q_sel, n_tg;
    logic signed [SUM_W-1:0] prod_a_ext, prod_ext2, n_sum, r_shift;
    logic signed [ANGLE_W-1:0] n_angle;

    assign in_beat         = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W - ANGLE_W){1'b0}}, r_out_data};

    assign in_ax = i_s_axis_tdata[IN_W-1:0];
    assign in_ay = i_s_axis_tdata[2*IN_W-1:IN_W];
    assign in_gz = i_s_axis_tdata[3*IN_W-1:2*IN_W];

    // result register free or being drained this cycle
    assign out_load = (r_state == S_OUT) && (!r_out_valid || i_m_axis_tready);

    // multiplier operand select
    assign gz_ext = r_gz;
    assign ta_ext = r_ta;
    assign w_comp = (CFG_W + 1)'(1 << CFG_W) - {1'b0, r_weight};

    always_comb begin
        case (r_state)
            S_PREP: begin
                mul_a = -gz_ext;
                mul_b = $signed(TG_W'(r_time_step));
            end
            S_MUL1: begin
                mul_a = $signed(MUL_A_W'(r_weight));
                mul_b = r_tg;
            end
            S_MUL2: begin
                mul_a = $signed(MUL_A_W'(w_comp));
                mul_b = ta_ext;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // m = floor((p * 2^fb + 131 * 2^15) / 2^16), then |m|, biased if m is negative, for a floor divide
    assign prod_ext = r_prod;
    assign n_wide   = (prod_ext <<< FRACTION_BITS) + GYRO_RND;
    assign n_shift  = n_wide >>> W_FRAC;
    assign m_bits   = r_m;
    assign n_dvd    = r_m[M_W-1] ? (~m_bits + NEG_BIAS) : m_bits;

    // cordic initial vector, mirrored into the right half plane
    assign ax_ext = r_ax;
    assign ay_ext = r_ay;
    assign x0     = (r_ax[IN_W-1] ? -ax_ext : ax_ext) <<< TABLE_BITS;
    assign y0     = (r_ax[IN_W-1] ? -ay_ext : ay_ext) <<< TABLE_BITS;

    assign sh     = TAB_IDX_W'(r_cnt);
    assign xs     = r_x >>> sh;
    assign ys     = r_y >>> sh;
    assign atan_z = $signed(ZW'(atan_deg(sh)));

    // remainder and next byte, quotient digit by reciprocal, new remainder
    assign dig_t = {r_rem, r_dvd[DVD_W-1 -: DIG_W]};
    assign dig_p = P_W'(dig_t) * P_W'(GYRO_RECIP);
    assign dig_q = dig_p[GYRO_RECIP_SH +: DIG_W];
    assign dig_r = dig_t - T_W'(dig_q) * T_W'(GYRO_DIVISOR);

    always_comb begin
        if (!r_ax[IN_W-1]) begin
            base = '0;
        end else if (r_ay[IN_W-1]) begin
            base = -BASE_180;
        end else begin
            base = BASE_180;
        end
    end

    assign z_fin = r_z + base + Z_HALF;
    assign z_sh  = z_fin >>> RND_SH;

    assign angle_ext = r_angle;
    assign q_ext     = $signed(TG_W'(r_quo[Q_W-1:0]));
    assign q_sel     = r_neg ? ~q_ext : q_ext;
    assign n_tg      = angle_ext + q_sel + $signed(TG_W'(r_neg));

    assign prod_a_ext = r_prod_a;
    assign prod_ext2  = r_prod;
    assign n_sum      = prod_a_ext + prod_ext2 + BLEND_RND;
    assign r_shift    = r_sum >>> W_FRAC;

    always_comb begin
        if (r_shift > SAT_MAX) begin
            n_angle = SAT_MAX[ANGLE_W-1:0];
        end else if (r_shift < SAT_MIN) begin
            n_angle = SAT_MIN[ANGLE_W-1:0];
        end else begin
            n_angle = r_shift[ANGLE_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_beat) n_state = S_PREP;
            S_PREP:  n_state = S_SCALE;
            S_SCALE: n_state = S_ABS;
            S_ABS:   n_state = S_ITER;
            S_ITER:  if (r_cnt == CNT_W'(ITER_CYC - 1)) n_state = S_ROUND;
            S_ROUND: n_state = S_MUL1;
            S_MUL1:  n_state = S_MUL2;
            S_MUL2:  n_state = S_SUM;
            S_SUM:   n_state = S_OUT;
            S_OUT:   if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_angle     <= '0;
            r_ax_ofs    <= '0;
            r_ay_ofs    <= '0;
            r_gz_ofs    <= '0;
            r_time_step <= TIME_STEP_RST;
            r_weight    <= GYRO_WEIGHT_RST;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_angle     <= n_angle;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_ACCEL_X_OFS: r_ax_ofs    <= i_cfg_wdata;
                    CFG_ACCEL_Y_OFS: r_ay_ofs    <= i_cfg_wdata;
                    CFG_GYRO_Z_OFS:  r_gz_ofs    <= i_cfg_wdata;
                    CFG_TIME_STEP:   r_time_step <= i_cfg_wdata;
                    CFG_GYRO_WEIGHT: r_weight    <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_ax <= in_ax + r_ax_ofs;
                r_ay <= in_ay + r_ay_ofs;
                r_gz <= in_gz + r_gz_ofs;
            end
            S_PREP: begin
                r_prod <= mul_p;
            end
            S_SCALE: begin
                r_m <= n_shift[M_W-1:0];
            end
            S_ABS: begin
                r_neg  <= r_m[M_W-1];
                r_dvd  <= DVD_W'(n_dvd);
                r_rem  <= '0;
                r_quo  <= '0;
                r_cnt  <= '0;
                r_x    <= x0;
                r_y    <= y0;
                r_z    <= '0;
                r_zero <= (r_ax == '0) && (r_ay == '0);
            end
            S_ITER: begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt < CNT_W'(NITER)) begin
                    // y at or below zero rotates the other way
                    if (r_y > 0) begin
                        r_x <= r_x + ys;
                        r_y <= r_y - xs;
                        r_z <= r_z + atan_z;
                    end else begin
                        r_x <= r_x - ys;
                        r_y <= r_y + xs;
                        r_z <= r_z - atan_z;
                    end
                end
                if (r_cnt < CNT_W'(NDIG)) begin
                    r_rem <= dig_r[REM_W-1:0];
                    r_dvd <= {r_dvd[DVD_W-DIG_W-1:0], {DIG_W{1'b0}}};
                    r_quo <= {r_quo[DVD_W-DIG_W-1:0], dig_q};
                end
            end
            S_ROUND: begin
                r_ta <= r_zero ? '0 : z_sh[TA_W-1:0];
                r_tg <= n_tg;
            end
            S_MUL1: begin
                r_prod <= mul_p;
            end
            S_MUL2: begin
                r_prod_a <= r_prod;
                r_prod   <= mul_p;
            end
            S_SUM: begin
                r_sum <= n_sum;
            end
            S_OUT: begin
                if (out_load) r_out_data <= n_angle;
            end
            default: ;
        endcase
    end

    `TCF_ASSERT(a_busy_after_accept, in_beat |=> !o_s_axis_tready)
    `TCF_ASSERT(a_out_is_state, o_m_axis_tvalid |-> (r_out_data == r_angle))
    `TCF_ASSERT(a_iter_bound, (r_state == S_ITER) |-> (r_cnt < CNT_W'(ITER_CYC)))
    `TCF_ASSERT(a_rem_bound,
        (r_state == S_ITER || r_state == S_ROUND) |-> (r_rem < REM_W'(GYRO_DIVISOR)))
    `TCF_ASSERT_CLK(a_angle_on_load, i_clk, i_rst_n,
        !$stable(r_angle) |-> $past(r_state == S_OUT))

endmodule

[tb/tcf_checker.sv]
`timescale 1ns / 1ps

module tcf_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    // accel_x_raw [15:0], accel_y_raw [31:16], gyro_z_raw [47:32]
    input  logic [tcf_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    // tilt_angle [27:0], zero fill [31:28]
    input  logic [tcf_pkg::OUT_TDATA_W-1:0] i_m_tdata,
    input  logic                            i_cfg_we,
    input  logic [tcf_pkg::CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [tcf_pkg::CFG_W-1:0]       i_cfg_wdata,
    output int                              o_errors,
    output int                              o_pending
);
    import tcf_pkg::*;

    localparam int ITERS = (CORDIC_ITERATIONS_DEF > TABLE_LEN) ? TABLE_LEN
                                                                : CORDIC_ITERATIONS_DEF;
    localparam int FB = FRACTION_BITS_DEF;
    localparam longint UNITY = longint'(1) <<< W_FRAC;
    localparam longint GYRO_DEN = GYRO_DIVISOR * UNITY;
    localparam longint ANGLE_HI = (longint'(1) <<< (ANGLE_W - 1)) - 1;
    localparam longint ANGLE_LO = -(longint'(1) <<< (ANGLE_W - 1));
    localparam longint HALF_TURN = longint'(180) <<< TABLE_BITS;

    // atan(2^-i) in degrees, 24 fraction bits
    localparam longint ATAN_STEP [0:TABLE_LEN-1] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335, 14668, 7334,
        3667, 1833, 917, 458, 229, 115
    };

    logic signed [IN_W-1:0] ofs_ax = '0;
    logic signed [IN_W-1:0] ofs_ay = '0;
    logic signed [IN_W-1:0] ofs_gz = '0;
    logic [CFG_W-1:0]       step_s = TIME_STEP_RST;
    logic [CFG_W-1:0]       weight_g = GYRO_WEIGHT_RST;
    longint                 angle_est = 0;
    int                     fail_cnt = 0;
    logic [ANGLE_W-1:0]     tilt_q [$];

    function automatic longint floor_div(input longint n, input longint d);
        longint q;
        q = n / d;
        if (n % d != 0 && n < 0)
            q--;
        return q;
    endfunction

    // vectoring cordic, left half plane folded over with a +-180 base
    function automatic longint accel_tilt(input longint ax, input longint ay);
        longint x, y, z, xs, ys;
        if (ax == 0 && ay == 0)
            return 0;
        x = ax <<< TABLE_BITS;
        y = ay <<< TABLE_BITS;
        z = 0;
        if (ax < 0) begin
            x = -x;
            y = -y;
            z = (ay >= 0) ? HALF_TURN : -HALF_TURN;
        end
        for (int i = 0; i < ITERS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_STEP[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_STEP[i];
            end
        end
        if (TABLE_BITS > FB)
            z = (z + (longint'(1) <<< (TABLE_BITS - FB - 1))) >>> (TABLE_BITS - FB);
        else
            z = z <<< (FB - TABLE_BITS);
        return z;
    endfunction

    // new blended angle; also advances the stored estimate
    function automatic logic [ANGLE_W-1:0] next_tilt(input logic [IN_TDATA_W-1:0] beat);
        logic signed [IN_W-1:0] ax, ay, gz;
        longint accel_deg, gyro_deg, num, w, acc, r;
        ax = beat[IN_W-1:0] + ofs_ax;
        ay = beat[2*IN_W-1:IN_W] + ofs_ay;
        gz = beat[3*IN_W-1:2*IN_W] + ofs_gz;
        accel_deg = accel_tilt(longint'(ax), longint'(ay));
        num = -longint'(gz) * longint'(step_s);
        num = num <<< FB;
        gyro_deg = angle_est + floor_div(2 * num + GYRO_DEN, 2 * GYRO_DEN);
        w = longint'(weight_g);
        acc = w * gyro_deg + (UNITY - w) * accel_deg;
        r = (acc + UNITY / 2) >>> W_FRAC;
        if (r > ANGLE_HI)
            r = ANGLE_HI;
        else if (r < ANGLE_LO)
            r = ANGLE_LO;
        angle_est = r;
        return r[ANGLE_W-1:0];
    endfunction

    always @(posedge i_clk) begin : monitor
        logic [OUT_TDATA_W-1:0] want;
        if (!i_rst_n) begin
            ofs_ax = '0;
            ofs_ay = '0;
            ofs_gz = '0;
            step_s = TIME_STEP_RST;
            weight_g = GYRO_WEIGHT_RST;
            angle_est = 0;
            tilt_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_addr))
                    CFG_ACCEL_X_OFS: ofs_ax = i_cfg_wdata;
                    CFG_ACCEL_Y_OFS: ofs_ay = i_cfg_wdata;
                    CFG_GYRO_Z_OFS:  ofs_gz = i_cfg_wdata;
                    CFG_TIME_STEP:   step_s = i_cfg_wdata;
                    CFG_GYRO_WEIGHT: weight_g = i_cfg_wdata;
                    default: ;
                endcase
            end
            // result beat is checked before this edge's sample is queued
            if (i_m_tvalid && i_m_tready) begin
                if (tilt_q.size() == 0) begin
                    $display("%0t: unexpected tilt beat: expected none, got %h",
                             $time, i_m_tdata);
                    fail_cnt++;
                end else begin
                    want = OUT_TDATA_W'(tilt_q.pop_front());
                    if (i_m_tdata !== want) begin
                        $display("%0t: tilt angle mismatch: expected %h, got %h",
                                 $time, want, i_m_tdata);
                        fail_cnt++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                tilt_q.push_back(next_tilt(i_s_tdata));
        end
        o_errors <= fail_cnt;
        o_pending <= tilt_q.size();
    end

endmodule

[tb/tb_tilt_complementary_filter.sv]
`timescale 1ns / 1ps

module tb_tilt_complementary_filter;
    import tcf_pkg::*;

    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 100;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 320;
    localparam int N_DIRECTED   = 18;

    // {gyro_z, accel_y, accel_x}
    localparam logic [IN_TDATA_W-1:0] DIRECTED [0:N_DIRECTED-1] = '{
        {16'h0000, 16'h0000, 16'h7fff},
        {16'h0000, 16'h0000, 16'h8000},
        {16'h0000, 16'h7fff, 16'h0000},
        {16'h0000, 16'h8000, 16'h0000},
        {16'h0000, 16'h0000, 16'h0000},
        {16'h0000, 16'h0000, 16'hffff},
        {16'h0000, 16'hffff, 16'hffff},
        {16'h0000, 16'h0001, 16'hffff},
        {16'h0000, 16'h7fff, 16'h7fff},
        {16'h0000, 16'h8000, 16'h7fff},
        {16'h0000, 16'h7fff, 16'h8000},
        {16'h0000, 16'h8000, 16'h8000},
        {16'h7fff, 16'h0000, 16'h0000},
        {16'h8000, 16'h0000, 16'h0000},
        {16'hffff, 16'h0000, 16'h0001},
        {16'h0001, 16'h0001, 16'h0000},
        {16'h5555, 16'haaaa, 16'h5555},
        {16'haaaa, 16'h5555, 16'haaaa}
    };

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_addr = '0;
    logic [CFG_W-1:0]       i_cfg_wdata = '0;

    int               errors;
    int               pending;
    int               send_idle_pct = 28;
    int               recv_idle_pct = 53;
    int               hold_req = 0;
    int               hold_seen = 0;
    int               hold_left = 0;
    int               quiet_cycles = 0;
    logic [CFG_W-1:0] cur_ofs_x = '0;
    logic [CFG_W-1:0] cur_ofs_y = '0;
    bit               gz_negative = 1'b0;

    tilt_complementary_filter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    tcf_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_axis_tvalid),
        .i_s_tready  (o_s_axis_tready),
        .i_s_tdata   (i_s_axis_tdata),
        .i_m_tvalid  (o_m_axis_tvalid),
        .i_m_tready  (i_m_axis_tready),
        .i_m_tdata   (o_m_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // result side: random backpressure, or a long hold when one is requested
    always @(negedge i_clk) begin
        if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            i_m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
                || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_ACCEL_X_OFS)
            cur_ofs_x = val;
        if (idx == CFG_ACCEL_Y_OFS)
            cur_ofs_y = val;
    endtask

    task automatic write_unmapped();
        for (int a = CFG_GYRO_WEIGHT + 1; a < (1 << CFG_IDX_W); a++)
            cfg_write(CFG_IDX_W'(a), CFG_W'($urandom));
    endtask

    task automatic send_sample(input logic [IN_W-1:0] ax, input logic [IN_W-1:0] ay,
                               input logic [IN_W-1:0] gz);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {gz, ay, ax};
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
    endtask

    // offsets applied by the block are undone here to aim at and around the origin
    task automatic send_random();
        logic [IN_W-1:0] ax, ay, gz;
        int kind;
        kind = $urandom_range(99);
        ax = $urandom;
        ay = $urandom;
        gz = $urandom;
        if (kind < 15) begin
            ax = IN_W'($urandom_range(6) - 3) - cur_ofs_x;
            ay = IN_W'($urandom_range(6) - 3) - cur_ofs_y;
        end else if (kind < 25) begin
            ax = -cur_ofs_x;
            ay = -cur_ofs_y;
        end else if (kind < 35) begin
            ax = ($urandom_range(1) != 0) ? 16'h8000 : 16'h7fff;
            ay = ($urandom_range(1) != 0) ? 16'hffff : 16'h0001;
        end
        if ($urandom_range(3) == 0)
            gz = gz_negative ? 16'h8000 : 16'h7fff;
        send_sample(ax, ay, gz);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || !o_s_axis_tready)
            @(posedge i_clk);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int ph = 0; ph < PHASES; ph++) begin
            send_idle_pct = (ph < 2) ? 28 : (ph < 4) ? 53 : 0;
            recv_idle_pct = (ph < 2) ? 53 : (ph < 4) ? 28 : 0;
            case (ph)
                0: begin
                    for (int i = 0; i < N_DIRECTED; i++)
                        send_sample(DIRECTED[i][IN_W-1:0], DIRECTED[i][2*IN_W-1:IN_W],
                                    DIRECTED[i][3*IN_W-1:2*IN_W]);
                end
                1: begin
                    // full step and full gyro weight drive the estimate into saturation
                    cfg_write(CFG_ACCEL_X_OFS, CFG_W'($urandom));
                    cfg_write(CFG_ACCEL_Y_OFS, CFG_W'($urandom));
                    cfg_write(CFG_GYRO_Z_OFS, CFG_W'($urandom));
                    cfg_write(CFG_TIME_STEP, 16'hffff);
                    cfg_write(CFG_GYRO_WEIGHT, 16'hffff);
                    write_unmapped();
                end
                2: begin
                    // zero gyro weight: accel angle alone
                    cfg_write(CFG_ACCEL_X_OFS, 16'h7fff);
                    cfg_write(CFG_ACCEL_Y_OFS, 16'h8000);
                    cfg_write(CFG_GYRO_Z_OFS, 16'h7fff);
                    cfg_write(CFG_TIME_STEP, 16'h0000);
                    cfg_write(CFG_GYRO_WEIGHT, 16'h0000);
                end
                3: begin
                    cfg_write(CFG_ACCEL_X_OFS, CFG_W'($urandom));
                    cfg_write(CFG_ACCEL_Y_OFS, CFG_W'($urandom));
                    cfg_write(CFG_GYRO_Z_OFS, CFG_W'($urandom));
                    cfg_write(CFG_TIME_STEP, CFG_W'($urandom));
                    cfg_write(CFG_GYRO_WEIGHT, CFG_W'($urandom));
                end
                4: begin
                    cfg_write(CFG_ACCEL_X_OFS, 16'h8000);
                    cfg_write(CFG_ACCEL_Y_OFS, 16'h7fff);
                    cfg_write(CFG_GYRO_Z_OFS, 16'h8000);
                    cfg_write(CFG_TIME_STEP, 16'h0001);
                    cfg_write(CFG_GYRO_WEIGHT, 16'h8000);
                    write_unmapped();
                end
                default: begin
                    cfg_write(CFG_ACCEL_X_OFS, '0);
                    cfg_write(CFG_ACCEL_Y_OFS, '0);
                    cfg_write(CFG_GYRO_Z_OFS, '0);
                    cfg_write(CFG_TIME_STEP, TIME_STEP_RST);
                    cfg_write(CFG_GYRO_WEIGHT, GYRO_WEIGHT_RST);
                end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i % 40 == 0)
                    gz_negative = ~gz_negative;
                // long result hold while samples keep coming
                if (i == PHASE_ITEMS / 2 && (ph == 1 || ph == 4))
                    hold_req++;
                if (i == PHASE_ITEMS / 2 && ph == 3)
                    wait_idle();
                send_random();
            end
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
